// ===== src/bma_pkg.sv =====
// Shared types, constants and the voltage-to-level mapping of the battery monitor audit block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bma_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SUPPLY_THRESHOLD = 3'd0,
    REG_AUDIT_PERIOD     = 3'd1,
    REG_FIRST_DELAY      = 3'd2,
    REG_REPORT_INTERVAL  = 3'd3,
    REG_REPORT_REPEATS   = 3'd4
  } bma_reg_e;

  // Configuration reset values.
  localparam logic [12:0] THRESHOLD_RST = 13'd4000;
  localparam logic [31:0] PERIOD_RST    = 32'd60000;
  localparam logic [31:0] DELAY_RST     = 32'd5000;
  localparam logic [31:0] INTERVAL_RST  = 32'd20000;
  localparam logic [7:0]  REPEATS_RST   = 8'd2;

  // Level mapping: 3300 mV is empty, 4200 mV is full, 900 mV span divided by 9 per percent.
  localparam logic [12:0] MV_EMPTY    = 13'd3300;
  localparam logic [12:0] MV_FULL     = 13'd4200;
  localparam logic [6:0]  PCT_FULL    = 7'd100;
  localparam logic [12:0] RECIP_NINTH = 13'd7282;  // ceil(2^16 / 9), exact below 900

  // Filter rounding term for the divide by eight.
  localparam logic [16:0] FILT_ROUND = 17'd4;

  // One history entry as stored in the memory.
  typedef struct packed {
    logic [31:0] rel_ms;
    logic [12:0] mv;
    logic [6:0]  pct;
  } bma_entry_t;

  // Per-tick flags that travel down the pipeline.
  typedef struct packed {
    logic        valid;
    logic        on_batt;
    logic        logged;
    logic        report;
    logic [12:0] filt_mv;
  } bma_flags_t;

  // Battery level in percent from a filtered voltage.
  function automatic logic [6:0] level_of(input logic [12:0] mv);
    logic [12:0] span;
    logic [22:0] prod;
    logic [6:0]  pct;
    span = mv - MV_EMPTY;
    prod = 23'(span[9:0]) * 23'(RECIP_NINTH);
    if (mv <= MV_EMPTY) begin
      pct = '0;
    end else if (mv >= MV_FULL) begin
      pct = PCT_FULL;
    end else begin
      pct = prod[22:16];
    end
    return pct;
  endfunction

endpackage

`default_nettype wire

// ===== src/bma_ctrl.sv =====
// Front stage: configuration registers, battery filter and the audit state machine registers.
// Depends on bma_pkg; feeds the history stage with the slot and sample of each tick.
`default_nettype none

module bma_ctrl import bma_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 90,
  localparam int unsigned IW = $clog2(HISTORY_DEPTH),
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1),
  localparam int unsigned SW = CW + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  wire logic          in_valid_i,
  input  wire logic [12:0]   vbat_mv_i,
  input  wire logic          vbat_ok_i,
  input  wire logic [12:0]   vin_mv_i,
  input  wire logic          vin_ok_i,
  input  wire logic [31:0]   now_ms_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  output bma_flags_t         s1_flags_o,
  output logic [12:0]        s1_mv_o,
  output logic [31:0]        s1_rel_ms_o,
  output logic [IW-1:0]      s1_slot_o,
  output logic [IW-1:0]      s1_oldest_o,
  output logic [CW-1:0]      s1_count_o
);

  logic [12:0]   thresh_q;
  logic [31:0]   period_q, delay_q, interval_q;
  logic [7:0]    repeats_q;

  logic [12:0]   filter_q, filter_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] oldest_q, oldest_d;
  logic [31:0]   start_q, start_d;
  logic [31:0]   last_q, last_d;
  logic          mode_q, mode_d;
  logic [31:0]   due_q, due_d;
  logic [7:0]    left_q, left_d;

  logic          accept;
  logic [16:0]   filt_acc;
  logic          on, enter, periodic, leave, logged, report;
  logic [CW-1:0] count_b;
  logic [IW-1:0] oldest_b, slot;
  logic [31:0]   start_b, start_l, due_b;
  logic [31:0]   due_diff;
  logic [7:0]    left_b;
  logic [SW-1:0] slot_sum;

  assign accept      = in_valid_i && advance_i;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= THRESHOLD_RST;
      period_q   <= PERIOD_RST;
      delay_q    <= DELAY_RST;
      interval_q <= INTERVAL_RST;
      repeats_q  <= REPEATS_RST;
    end else if (cfg_valid_i) begin
      case (bma_reg_e'(cfg_index_i))
        REG_SUPPLY_THRESHOLD: thresh_q   <= cfg_data_i[12:0];
        REG_AUDIT_PERIOD:     period_q   <= cfg_data_i;
        REG_FIRST_DELAY:      delay_q    <= cfg_data_i;
        REG_REPORT_INTERVAL:  interval_q <= cfg_data_i;
        REG_REPORT_REPEATS:   repeats_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Smoothing filter: 7/8 old plus 1/8 new, rounded; an empty filter loads the sample.
  always_comb begin
    filt_acc = {1'b0, filter_q, 3'b000} - {4'b0, filter_q} + {4'b0, vbat_mv_i} + FILT_ROUND;
    filter_d = filter_q;
    if (vbat_ok_i) begin
      filter_d = (filter_q == '0) ? vbat_mv_i : filt_acc[15:3];
    end
  end

  // Audit step: mode change, sample logging into the ring and report scheduling.
  always_comb begin
    on       = vin_mv_i <= thresh_q;
    enter    = vin_ok_i && on && !mode_q;
    periodic = vin_ok_i && on && mode_q && ((now_ms_i - last_q) >= period_q);
    leave    = vin_ok_i && !on && mode_q;
    logged   = enter || periodic || leave;

    // Entering battery mode restarts the history and the report schedule.
    count_b  = enter ? '0 : count_q;
    oldest_b = enter ? '0 : oldest_q;
    start_b  = enter ? now_ms_i : start_q;
    left_b   = enter ? '0 : (leave ? repeats_q : left_q);
    due_b    = enter ? '0 : (leave ? (now_ms_i + delay_q) : due_q);

    // A start time of zero counts as not started.
    start_l  = (start_b == '0) ? now_ms_i : start_b;

    slot_sum = SW'(oldest_b) + SW'(count_b);
    if (slot_sum >= SW'(HISTORY_DEPTH)) begin
      slot_sum = slot_sum - SW'(HISTORY_DEPTH);
    end

    count_d  = count_q;
    oldest_d = oldest_q;
    start_d  = start_q;
    last_d   = last_q;
    slot     = slot_sum[IW-1:0];
    if (logged) begin
      start_d = start_l;
      last_d  = now_ms_i;
      if (count_b != CW'(HISTORY_DEPTH)) begin
        count_d  = count_b + 1'b1;
        oldest_d = oldest_b;
      end else begin
        slot     = oldest_b;
        count_d  = count_b;
        oldest_d = (oldest_b == IW'(HISTORY_DEPTH - 1)) ? '0 : oldest_b + 1'b1;
      end
    end

    // Report goes out once the due time is reached, read as a signed difference.
    due_diff = now_ms_i - due_b;
    report   = vin_ok_i && !on && (left_b != '0) && !due_diff[31];
    left_d   = left_q;
    due_d    = due_q;
    if (vin_ok_i) begin
      left_d = report ? left_b - 1'b1 : left_b;
      due_d  = report ? now_ms_i + interval_q : due_b;
    end
    mode_d = vin_ok_i ? on : mode_q;
  end

  // State registers, updated once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= '0;
      count_q  <= '0;
      oldest_q <= '0;
      start_q  <= '0;
      last_q   <= '0;
      mode_q   <= 1'b0;
      due_q    <= '0;
      left_q   <= '0;
    end else if (accept) begin
      filter_q <= filter_d;
      count_q  <= count_d;
      oldest_q <= oldest_d;
      start_q  <= start_d;
      last_q   <= last_d;
      mode_q   <= mode_d;
      due_q    <= due_d;
      left_q   <= left_d;
    end
  end

  // Stage register towards the history memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_flags_o <= '0;
    end else if (advance_i) begin
      s1_flags_o.valid   <= accept;
      s1_flags_o.on_batt <= mode_d;
      s1_flags_o.logged  <= logged;
      s1_flags_o.report  <= report;
      s1_flags_o.filt_mv <= filter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_mv_o     <= vbat_ok_i ? vbat_mv_i : '0;
      s1_rel_ms_o <= now_ms_i - start_l;
      s1_slot_o   <= slot;
      s1_oldest_o <= oldest_d;
      s1_count_o  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/bma_hist.sv =====
// History stage: the sample memory, level mapping, newest-sample registers and oldest-entry read.
// Depends on bma_pkg; driven by bma_ctrl and read by the top-level output stage.
`default_nettype none

module bma_hist import bma_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 90,
  localparam int unsigned IW = $clog2(HISTORY_DEPTH),
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  wire bma_flags_t    s1_flags_i,
  input  wire logic [12:0]   s1_mv_i,
  input  wire logic [31:0]   s1_rel_ms_i,
  input  wire logic [IW-1:0] s1_slot_i,
  input  wire logic [IW-1:0] s1_oldest_i,
  input  wire logic [CW-1:0] s1_count_i,
  output bma_flags_t         s2_flags_o,
  output logic [6:0]         s2_pct_o,
  output logic [CW-1:0]      s2_count_o,
  output bma_entry_t         s2_last_o,
  output bma_entry_t         s2_first_o
);

  bma_entry_t mem_q [HISTORY_DEPTH];
  bma_entry_t newest_q, newest_d;
  bma_entry_t wr_entry;
  logic [6:0] pct;
  logic       wr_en;

  // Level follows the filtered voltage of this tick.
  always_comb begin
    pct             = level_of(s1_flags_i.filt_mv);
    wr_entry.rel_ms = s1_rel_ms_i;
    wr_entry.mv     = s1_mv_i;
    wr_entry.pct    = pct;
    wr_en           = advance_i && s1_flags_i.valid && s1_flags_i.logged;
    newest_d        = s1_flags_i.logged ? wr_entry : newest_q;
  end

  // Sample memory: one write port for the new sample, one read port for the oldest entry.
  // With two or more samples the written slot never equals the oldest one.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_slot_i] <= wr_entry;
    end
    if (advance_i) begin
      s2_first_o <= mem_q[s1_oldest_i];
    end
  end

  // The newest sample is kept in registers.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      newest_q <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_flags_o <= '0;
    end else if (advance_i) begin
      s2_flags_o <= s1_flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s2_pct_o   <= pct;
      s2_count_o <= s1_count_i;
      s2_last_o  <= newest_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/battery_monitor_audit.sv =====
// Battery monitor audit top level: front stage, history stage and the result register.
// Depends on bma_pkg, bma_ctrl and bma_hist.
//
// One reading tick enters per clock cycle unless the result stalls; its result passes
// the front stage, the history memory access and the result register. The rate is
// set by the history memory, which takes one sample write and one oldest-entry read
// in every cycle; the filter and audit state update in the front stage within the
// accepting cycle, so ticks follow each other without gaps. The history memory needs
// no clearing pass after reset: entries are only used once written. A stalled result
// holds the pipeline, and the input stall follows it in the same cycle.
`default_nettype none

module battery_monitor_audit import bma_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 90,
  localparam int unsigned IW = $clog2(HISTORY_DEPTH),
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [12:0] vbat_mv_i,
  input  wire logic        vbat_ok_i,
  input  wire logic [12:0] vin_mv_i,
  input  wire logic        vin_ok_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       level_percent_o,
  output logic [12:0]      filtered_mv_o,
  output logic             batt_mode_o,
  output logic             sample_logged_o,
  output logic             report_valid_o,
  output logic [6:0]       report_count_o,
  output logic [31:0]      report_elapsed_ms_o,
  output logic [12:0]      report_first_mv_o,
  output logic [12:0]      report_last_mv_o,
  output logic [6:0]       report_first_percent_o,
  output logic [6:0]       report_last_percent_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic          advance;
  bma_flags_t    s1_flags, s2_flags;
  logic [12:0]   s1_mv;
  logic [31:0]   s1_rel_ms;
  logic [IW-1:0] s1_slot, s1_oldest;
  logic [CW-1:0] s1_count, s2_count;
  logic [6:0]    s2_pct;
  bma_entry_t    s2_last, s2_first;

  logic          out_valid_q;
  logic          rpt_full;
  logic [31:0]   elapsed;

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !advance;
  assign out_valid_o = out_valid_q;

  bma_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .in_valid_i  (in_valid_i),
    .vbat_mv_i   (vbat_mv_i),
    .vbat_ok_i   (vbat_ok_i),
    .vin_mv_i    (vin_mv_i),
    .vin_ok_i    (vin_ok_i),
    .now_ms_i    (now_ms_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s1_flags_o  (s1_flags),
    .s1_mv_o     (s1_mv),
    .s1_rel_ms_o (s1_rel_ms),
    .s1_slot_o   (s1_slot),
    .s1_oldest_o (s1_oldest),
    .s1_count_o  (s1_count)
  );

  bma_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .s1_flags_i  (s1_flags),
    .s1_mv_i     (s1_mv),
    .s1_rel_ms_i (s1_rel_ms),
    .s1_slot_i   (s1_slot),
    .s1_oldest_i (s1_oldest),
    .s1_count_i  (s1_count),
    .s2_flags_o  (s2_flags),
    .s2_pct_o    (s2_pct),
    .s2_count_o  (s2_count),
    .s2_last_o   (s2_last),
    .s2_first_o  (s2_first)
  );

  // Report span from oldest to newest sample, never zero when two or more samples are held.
  always_comb begin
    rpt_full = s2_flags.report && (s2_count >= CW'(2));
    elapsed  = s2_last.rel_ms - s2_first.rel_ms;
    if (elapsed == '0) begin
      elapsed = 32'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_flags.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_flags.valid) begin
      level_percent_o        <= s2_pct;
      filtered_mv_o          <= s2_flags.filt_mv;
      batt_mode_o            <= s2_flags.on_batt;
      sample_logged_o        <= s2_flags.logged;
      report_valid_o         <= s2_flags.report;
      report_count_o         <= s2_flags.report ? 7'(s2_count) : '0;
      report_elapsed_ms_o    <= rpt_full ? elapsed : '0;
      report_first_mv_o      <= rpt_full ? s2_first.mv : '0;
      report_last_mv_o       <= rpt_full ? s2_last.mv : '0;
      report_first_percent_o <= rpt_full ? s2_first.pct : '0;
      report_last_percent_o  <= rpt_full ? s2_last.pct : '0;
    end
  end

endmodule

`default_nettype wire
